// ===== hw/rtl/mmpc_pkg.sv =====
// Shared types and constants for the Manhattan median point count block.
`default_nettype none

package mmpc_pkg;

   // Default store depth and kept coordinate width.
   localparam int MAX_POINTS_DEF = 1024;
   localparam int COORD_BITS_DEF = 31;

   // Fixed widths of the beat fields.
   localparam int IN_COORD_W = 31;
   localparam int COUNT_W    = 63;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_SUCC,
      ST_MUL,
      ST_OUT
   } mmpc_state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/manhattan_median_point_count.sv =====
// Top level: point store, radix selection sequencer and result multiplier.
`default_nettype none

// Points arrive one per cycle while the block is loading a set, into an X
// store and a Y store (one beat per point, MAX_POINTS deep; extra points are
// dropped and flagged). A beat with last_point set closes the set. An odd or
// single-point set returns a count of 1 on the next cycle. An even set of n
// points runs a bitwise radix selection for the lower middle value of each
// coordinate, then one more scan for the upper middle value: COORD_BITS + 1
// scans per coordinate, each reading every stored value in turn through the
// single read port of the stores and the shared count and compare unit.
// No new point is taken until the result beat has been delivered.
module manhattan_median_point_count
   import mmpc_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [IN_COORD_W-1:0] req_point_x,
   input  wire logic [IN_COORD_W-1:0] req_point_y,
   input  wire logic                  req_last_point,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [COUNT_W-1:0]         rsp_optimal_count,
   output logic                       rsp_overflowed
);

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int SPAN_W = COORD_BITS + 1;
   localparam logic [COORD_BITS-1:0] TOP_BIT = COORD_BITS'(1) << (COORD_BITS - 1);
   localparam logic [COORD_BITS-1:0] ALL_ONES = '1;

   // Point stores.
   logic [COORD_BITS-1:0] x_mem [MAX_POINTS];
   logic [COORD_BITS-1:0] y_mem [MAX_POINTS];

   mmpc_state_type state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic                  y_pass_ff, y_pass_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  rd_last_ff, rd_last_in;
   logic [COORD_BITS-1:0] x_rd_ff, y_rd_ff;
   logic [COORD_BITS-1:0] bit_sel_ff, bit_sel_in;
   logic [COORD_BITS-1:0] mask_ff, mask_in;
   logic [COORD_BITS-1:0] prefix_ff, prefix_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic [CNT_W-1:0]      zcnt_ff, zcnt_in;
   logic [CNT_W-1:0]      le_cnt_ff, le_cnt_in;
   logic [COORD_BITS-1:0] min_gt_ff, min_gt_in;
   logic [SPAN_W-1:0]     span_x_ff, span_x_in;
   logic [SPAN_W-1:0]     span_y_ff, span_y_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic                  req_take;
   logic                  mem_we;
   logic [IDX_W-1:0]      wr_addr;
   logic [IDX_W-1:0]      rd_addr;
   logic                  rd_issue;
   logic [CNT_W-1:0]      rd_next;
   logic [CNT_W-1:0]      half;
   logic [COORD_BITS-1:0] rd_val;
   logic                  zero_hit;
   logic                  le_hit;
   logic                  gt_lower;
   logic [CNT_W-1:0]      zcnt_now;
   logic [CNT_W-1:0]      le_now;
   logic [COORD_BITS-1:0] min_now;
   logic [COORD_BITS-1:0] upper_mid;
   logic [SPAN_W-1:0]     span_now;
   logic                  pass_end;
   logic [2*SPAN_W-1:0]   span_prod;

   // Shared scan datapath: one stored value per cycle against the prefix.
   assign req_take  = req_valid && !req_stall;
   assign wr_addr   = count_ff[IDX_W-1:0];
   assign rd_addr   = rd_idx_ff[IDX_W-1:0];
   assign rd_issue  = (rd_idx_ff < count_ff);
   assign rd_next   = rd_idx_ff + CNT_W'(1);
   assign half      = count_ff >> 1;
   assign rd_val    = y_pass_ff ? y_rd_ff : x_rd_ff;
   assign zero_hit  = (((rd_val ^ prefix_ff) & mask_ff) == '0) && ((rd_val & bit_sel_ff) == '0);
   assign le_hit    = (rd_val <= prefix_ff);
   assign gt_lower  = !le_hit && (rd_val < min_gt_ff);
   assign zcnt_now  = zcnt_ff + CNT_W'(rd_vld_ff && zero_hit);
   assign le_now    = le_cnt_ff + CNT_W'(rd_vld_ff && le_hit);
   assign min_now   = (rd_vld_ff && gt_lower) ? rd_val : min_gt_ff;
   assign upper_mid = (le_now > half) ? prefix_ff : min_now;
   assign span_now  = {1'b0, upper_mid} - {1'b0, prefix_ff} + SPAN_W'(1);
   assign pass_end  = rd_vld_ff && rd_last_ff;

   // Full-width product of the two spans.
   assign span_prod = span_x_ff * span_y_ff;

   // Store write on a kept point, registered read for the scans.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         x_mem[wr_addr] <= req_point_x[COORD_BITS-1:0];
         y_mem[wr_addr] <= req_point_y[COORD_BITS-1:0];
      end
      x_rd_ff <= x_mem[rd_addr];
      y_rd_ff <= y_mem[rd_addr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         y_pass_ff    <= 1'b0;
         rd_idx_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         y_pass_ff    <= y_pass_in;
         rd_idx_ff    <= rd_idx_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rd_last_ff   <= rd_last_in;
      bit_sel_ff   <= bit_sel_in;
      mask_ff      <= mask_in;
      prefix_ff    <= prefix_in;
      k_ff         <= k_in;
      zcnt_ff      <= zcnt_in;
      le_cnt_ff    <= le_cnt_in;
      min_gt_ff    <= min_gt_in;
      span_x_ff    <= span_x_in;
      span_y_ff    <= span_y_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // Sequencer: next state and datapath controls.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      y_pass_in    = y_pass_ff;
      rd_idx_in    = rd_idx_ff;
      rd_vld_in    = 1'b0;
      rd_last_in   = 1'b0;
      bit_sel_in   = bit_sel_ff;
      mask_in      = mask_ff;
      prefix_in    = prefix_ff;
      k_in         = k_ff;
      zcnt_in      = zcnt_ff;
      le_cnt_in    = le_cnt_ff;
      min_gt_in    = min_gt_ff;
      span_x_in    = span_x_ff;
      span_y_in    = span_y_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mem_we       = 1'b0;
      req_stall    = (state_ff != ST_LOAD);

      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (count_ff < CNT_W'(MAX_POINTS)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_point) begin
                  if ((count_in >= CNT_W'(2)) && !count_in[0]) begin
                     // Even set: start the radix search on X.
                     state_in   = ST_SCAN;
                     y_pass_in  = 1'b0;
                     rd_idx_in  = '0;
                     bit_sel_in = TOP_BIT;
                     mask_in    = '0;
                     prefix_in  = '0;
                     k_in       = (count_in >> 1) - CNT_W'(1);
                     zcnt_in    = '0;
                  end else begin
                     state_in     = ST_OUT;
                     rsp_valid_in = 1'b1;
                     rsp_count_in = COUNT_W'(1);
                     rsp_ovf_in   = ovf_in;
                  end
               end
            end
         end

         ST_SCAN: begin
            // Count values that match the prefix and have a zero at this bit.
            if (rd_issue) begin
               rd_idx_in  = rd_next;
               rd_vld_in  = 1'b1;
               rd_last_in = (rd_next == count_ff);
            end
            zcnt_in = zcnt_now;
            if (pass_end) begin
               if (k_ff >= zcnt_now) begin
                  prefix_in = prefix_ff | bit_sel_ff;
                  k_in      = k_ff - zcnt_now;
               end
               mask_in    = mask_ff | bit_sel_ff;
               bit_sel_in = bit_sel_ff >> 1;
               zcnt_in    = '0;
               rd_idx_in  = '0;
               if (bit_sel_ff[0]) begin
                  state_in  = ST_SUCC;
                  le_cnt_in = '0;
                  min_gt_in = ALL_ONES;
               end
            end
         end

         ST_SUCC: begin
            // Lower middle value is in the prefix; find the next order statistic.
            if (rd_issue) begin
               rd_idx_in  = rd_next;
               rd_vld_in  = 1'b1;
               rd_last_in = (rd_next == count_ff);
            end
            le_cnt_in = le_now;
            min_gt_in = min_now;
            if (pass_end) begin
               rd_idx_in = '0;
               if (!y_pass_ff) begin
                  span_x_in  = span_now;
                  y_pass_in  = 1'b1;
                  state_in   = ST_SCAN;
                  bit_sel_in = TOP_BIT;
                  mask_in    = '0;
                  prefix_in  = '0;
                  k_in       = half - CNT_W'(1);
                  zcnt_in    = '0;
               end else begin
                  span_y_in = span_now;
                  state_in  = ST_MUL;
               end
            end
         end

         ST_MUL: begin
            rsp_count_in = COUNT_W'(span_prod);
            rsp_ovf_in   = ovf_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT;
         end

         ST_OUT: begin
            // Hold the result beat until taken, then open a new set.
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = ST_LOAD;
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_optimal_count = rsp_count_ff;
   assign rsp_overflowed    = rsp_ovf_ff;

   // No point is taken while a result beat is pending.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("point taken while result pending");

   // The fill count never passes the store depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond store depth");

   // A delivered result clears the set.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> (count_ff == '0) && !ovf_ff)
      else $error("set not cleared after result");

   // The selection rank stays below the set size during the radix search.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (k_ff < count_ff))
      else $error("selection rank out of range");

endmodule

`default_nettype wire
